@@ hw/rtl/mdd_pkg.sv @@
package mdd_pkg;

  localparam int RING_DEPTH  = 16384;
  localparam int TAP_COUNT   = 6;
  localparam int OUT_TAPS    = 6;
  localparam int ACTIVE_TAPS = (TAP_COUNT < OUT_TAPS) ? TAP_COUNT : OUT_TAPS;
  localparam int RING_AW     = $clog2(RING_DEPTH);

  localparam int TAP_W    = 3;
  localparam int DLY_W    = 14;
  localparam int GAIN_W   = 16;
  localparam int ALPHA_W  = 15;
  localparam int MIX_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam int MEM_W    = 24;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 64;

  localparam int MUL_AW = 25;
  localparam int MUL_BW = 33;
  localparam int PROD_W = MUL_AW + MUL_BW;
  localparam int ACC_W  = 41;
  localparam int SUM_W  = 42;

  typedef enum logic [CFG_AW-1:0] {
    CFG_DELAYS_LO = 3'd0,
    CFG_DELAYS_HI = 3'd1,
    CFG_GAINS_LO  = 3'd2,
    CFG_GAINS_HI  = 3'd3,
    CFG_ALPHA     = 3'd4,
    CFG_MIX       = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_ROUND,
    ST_OUT
  } state_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEM_W-1:0]    lp_t;

endpackage

@@ hw/rtl/mdd_ram.sv @@
module mdd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/multitap_damped_delay_top.sv @@
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid/s_axis_tready    mono_sample
// m_axis    out        m_axis_tvalid/m_axis_tready    reflection_tap0..5
// cfg       in         cfg_valid_i/cfg_ready_o        cfg_addr_i, cfg_data_i
//
// The ring is written at the edge that accepts a beat. Each tap then steps through READ, MUL1 to
// MUL4 and ROUND on the single shared multiplier, and the OUT state loads the output.
// The next beat can be accepted in the cycle after the load, so beats are never overlapped.
// The output register frees the input side while a result waits, but a finished item
// waits in the output state until the previous result has been taken.
// Reset clears the control state, the write pointer, the ring fill flag and the filters.
// Ring entries that were never written read as zero, so there is no clearing pass.
module multitap_damped_delay_top (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // Fields from bit 0: mono_sample.
  input  logic [mdd_pkg::SAMPLE_W-1:0]                 s_axis_tdata,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // Fields from bit 0: reflection_tap0 to reflection_tap5, 16 bits each.
  output logic [mdd_pkg::OUT_TAPS*mdd_pkg::SAMPLE_W-1:0] m_axis_tdata,
  input  logic                                         cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  logic [mdd_pkg::CFG_AW-1:0]                   cfg_addr_i,
  input  logic [mdd_pkg::CFG_DW-1:0]                   cfg_data_i
);

  import mdd_pkg::*;

  localparam int SUB_W = (RING_AW > DLY_W) ? RING_AW : DLY_W;

  logic [4*DLY_W-1:0]  dly_lo_q;
  logic [2*DLY_W-1:0]  dly_hi_q;
  logic [4*GAIN_W-1:0] gain_lo_q;
  logic [2*GAIN_W-1:0] gain_hi_q;
  logic [ALPHA_W-1:0]  alpha_q;
  logic [MIX_W-1:0]    mix_q;

  state_e state_q, state_d;
  logic [TAP_W-1:0]         tap_q;
  logic [RING_AW-1:0]       wp_q;
  logic                     full_q;
  logic                     rvalid_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] prod_q;
  lp_t                      m_q;
  lp_t                      lp_q  [OUT_TAPS];
  sample_t                  res_q [OUT_TAPS];
  sample_t                  out_q [OUT_TAPS];
  logic                     out_valid_q;

  logic                     in_fire;
  logic                     ld_out;
  logic                     last_tap;
  logic [DLY_W-1:0]         tap_dly  [OUT_TAPS];
  logic [GAIN_W-1:0]        tap_gain [OUT_TAPS];
  logic [SUB_W-1:0]         diff;
  logic [RING_AW-1:0]       rd_idx;
  logic                     rd_ok;
  logic [SAMPLE_W-1:0]      ram_rdata;
  sample_t                  x;
  logic [15:0]              one_minus_a;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [SUM_W-1:0]  lp_sum;
  lp_t                      m_new;
  logic signed [PROD_W-1:0] r_sum;
  logic signed [19:0]       r_full;
  sample_t                  r_sat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_lo_q  <= 56'd4398314962944;
      dly_hi_q  <= 28'd16385;
      gain_lo_q <= '0;
      gain_hi_q <= '0;
      alpha_q   <= '0;
      mix_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_DELAYS_LO: dly_lo_q  <= cfg_data_i[4*DLY_W-1:0];
        CFG_DELAYS_HI: dly_hi_q  <= cfg_data_i[2*DLY_W-1:0];
        CFG_GAINS_LO:  gain_lo_q <= cfg_data_i[4*GAIN_W-1:0];
        CFG_GAINS_HI:  gain_hi_q <= cfg_data_i[2*GAIN_W-1:0];
        CFG_ALPHA:     alpha_q   <= cfg_data_i[ALPHA_W-1:0];
        CFG_MIX:       mix_q     <= cfg_data_i[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tap_dly[k]  = dly_lo_q[k*DLY_W +: DLY_W];
      tap_gain[k] = gain_lo_q[k*GAIN_W +: GAIN_W];
    end
    tap_dly[4]  = dly_hi_q[DLY_W-1:0];
    tap_dly[5]  = dly_hi_q[2*DLY_W-1:DLY_W];
    tap_gain[4] = gain_hi_q[GAIN_W-1:0];
    tap_gain[5] = gain_hi_q[2*GAIN_W-1:GAIN_W];
  end

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign last_tap = (tap_q == TAP_W'(ACTIVE_TAPS - 1));

  assign diff   = SUB_W'(wp_q) - SUB_W'(tap_dly[tap_q]);
  assign rd_idx = diff[RING_AW-1:0];
  assign rd_ok  = full_q || (rd_idx <= wp_q);

  mdd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (in_fire),
    .waddr_i(wp_q),
    .wdata_i(s_axis_tdata),
    .re_i   (state_q == ST_READ),
    .raddr_i(rd_idx),
    .rdata_o(ram_rdata)
  );

  assign x           = rvalid_q ? sample_t'(ram_rdata) : '0;
  assign one_minus_a = 16'd32768 - {1'b0, alpha_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MUL1: begin
        mul_a = {{(MUL_AW-SAMPLE_W){x[SAMPLE_W-1]}}, x};
        mul_b = {{(MUL_BW-16){1'b0}}, one_minus_a};
      end
      ST_MUL2: begin
        mul_a = {{(MUL_AW-MEM_W){lp_q[tap_q][MEM_W-1]}}, lp_q[tap_q]};
        mul_b = {{(MUL_BW-ALPHA_W){1'b0}}, alpha_q};
      end
      ST_MUL3: begin
        mul_a = {{(MUL_AW-GAIN_W){1'b0}}, tap_gain[tap_q]};
        mul_b = {{(MUL_BW-MIX_W){1'b0}}, mix_q};
      end
      ST_MUL4: begin
        mul_a = {{(MUL_AW-MEM_W){m_q[MEM_W-1]}}, m_q};
        mul_b = {1'b0, prod_q[31:0]};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign lp_sum = {acc_q[ACC_W-1], acc_q} + prod_q[SUM_W-1:0] + SUM_W'(16384);
  assign m_new  = lp_sum[MEM_W+14:15];

  assign r_sum  = prod_q + (PROD_W'(1) << 37);
  assign r_full = r_sum[PROD_W-1:38];

  always_comb begin
    priority if (r_full > 20'sd32767) begin
      r_sat = 16'sh7fff;
    end else if (r_full < -20'sd32768) begin
      r_sat = 16'sh8000;
    end else begin
      r_sat = r_full[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_d       = state_q;
    ld_out        = 1'b0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_READ;
        end
      end
      ST_READ:  state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_MUL3;
      ST_MUL3:  state_d = ST_MUL4;
      ST_MUL4:  state_d = ST_ROUND;
      ST_ROUND: state_d = last_tap ? ST_OUT : ST_READ;
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          ld_out  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q       <= '0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < OUT_TAPS; k++) begin
        lp_q[k] <= '0;
      end
    end else begin
      if (in_fire) begin
        tap_q <= '0;
      end
      if (state_q == ST_READ) begin
        rvalid_q <= rd_ok;
      end
      if (state_q == ST_MUL3) begin
        lp_q[tap_q] <= m_new;
      end
      if ((state_q == ST_ROUND) && !last_tap) begin
        tap_q <= tap_q + TAP_W'(1);
      end
      if (ld_out) begin
        out_valid_q <= 1'b1;
        wp_q        <= wp_q + RING_AW'(1);
        if (&wp_q) begin
          full_q <= 1'b1;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (state_q == ST_MUL2) begin
      acc_q <= {prod_q[32:0], 8'b0};
    end
    if (state_q == ST_MUL3) begin
      m_q <= m_new;
    end
    if (state_q == ST_ROUND) begin
      res_q[tap_q] <= r_sat;
    end
    if (ld_out) begin
      for (int k = 0; k < OUT_TAPS; k++) begin
        out_q[k] <= res_q[k];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;

  for (genvar g = 0; g < OUT_TAPS; g++) begin : g_out
    if (g < ACTIVE_TAPS) begin : g_act
      assign m_axis_tdata[g*SAMPLE_W +: SAMPLE_W] = out_q[g];
    end else begin : g_off
      assign m_axis_tdata[g*SAMPLE_W +: SAMPLE_W] = '0;
    end
  end

endmodule

@@ hw/rtl/mdd_checker.sv @@
module mdd_checker (
  input logic                                         clk_i,
  input logic                                         rst_ni,
  input logic                                         s_axis_tvalid,
  input logic                                         s_axis_tready,
  input logic                                         m_axis_tvalid,
  input logic                                         m_axis_tready,
  input logic [mdd_pkg::OUT_TAPS*mdd_pkg::SAMPLE_W-1:0] m_axis_tdata
);

  // A result beat that is held back must stay unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // After a beat is taken, the block is busy for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  // A new result is only loaded from the busy state.
  a_load_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while input side was idle");

  // Reset keeps the result side empty.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind multitap_damped_delay_top mdd_checker u_mdd_checker (.*);

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mdd_pkg::*;

  localparam int OUT_W          = OUT_TAPS * SAMPLE_W;
  localparam int STALL_LIMIT    = 4000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 80;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 135;
  localparam int MAX_REPORTS    = 100;

  // Indexes outside the register map; writes to them must be ignored.
  localparam logic [CFG_AW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_SPARE_B = 3'd7;

  localparam logic [4*DLY_W-1:0] DELAYS_LO_RST = 56'd4398314962944;
  localparam logic [2*DLY_W-1:0] DELAYS_HI_RST = 28'd16385;

  typedef enum logic {ROW_SETTING, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] value;
    bit                fixed;
    logic [OUT_W-1:0]  reflections;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_AW-1:0]   cfg_addr_i;
  logic [CFG_DW-1:0]   cfg_data_i;

  // Shadow of the register file and of the echo state.
  logic [4*DLY_W-1:0]  dly_lo_q;
  logic [2*DLY_W-1:0]  dly_hi_q;
  logic [4*GAIN_W-1:0] gain_lo_q;
  logic [2*GAIN_W-1:0] gain_hi_q;
  logic [ALPHA_W-1:0]  alpha_q;
  logic [MIX_W-1:0]    mix_q;
  sample_t             echo_ring [RING_DEPTH];
  logic [RING_AW-1:0]  echo_wr_ptr;
  longint              damp_mem [OUT_TAPS];

  logic [OUT_W-1:0] reflections_due [$];
  dir_row_t         dir_rows [$];

  int err_cnt          = 0;
  int results_seen     = 0;
  int items_sent       = 0;
  int settings_written = 0;
  int idle_cycles      = 0;
  int tx_idle_pct      = 0;
  int rx_stall_pct     = 0;
  int hold_token       = 0;
  int hold_seen        = 0;
  int hold_left        = 0;

  multitap_damped_delay_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [OUT_W-1:0] predict_reflections(input sample_t smp);
    logic [DLY_W-1:0]   dly;
    logic [RING_AW-1:0] rd_ptr;
    longint             x, m, r, g, a, mx;
    logic [OUT_W-1:0]   res;
    int                 k;
    res = '0;
    a   = longint'(alpha_q);
    mx  = longint'(mix_q);
    echo_ring[echo_wr_ptr] = smp;
    for (k = 0; k < ACTIVE_TAPS; k++) begin
      if (k < 4) begin
        dly = dly_lo_q[DLY_W*k +: DLY_W];
        g   = longint'(gain_lo_q[GAIN_W*k +: GAIN_W]);
      end else begin
        dly = dly_hi_q[DLY_W*(k-4) +: DLY_W];
        g   = longint'(gain_hi_q[GAIN_W*(k-4) +: GAIN_W]);
      end
      rd_ptr = echo_wr_ptr - dly;
      x = longint'(echo_ring[rd_ptr]);
      m = ((32768 - a) * (x * 256) + a * damp_mem[k] + 16384) >>> 15;
      damp_mem[k] = m;
      r = (m * g * mx + (longint'(1) <<< 37)) >>> 38;
      if (r > 32767) begin
        r = 32767;
      end else if (r < -32768) begin
        r = -32768;
      end
      res[SAMPLE_W*k +: SAMPLE_W] = r[SAMPLE_W-1:0];
    end
    echo_wr_ptr = echo_wr_ptr + RING_AW'(1);
    return res;
  endfunction

  task automatic add_row(input row_kind_e kind, input logic [CFG_AW-1:0] addr,
                         input logic [CFG_DW-1:0] value, input bit fixed,
                         input logic [OUT_W-1:0] reflections);
    dir_row_t row;
    row.kind        = kind;
    row.addr        = addr;
    row.value       = value;
    row.fixed       = fixed;
    row.reflections = reflections;
    dir_rows.push_back(row);
  endtask

  task automatic write_setting(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (addr)
      CFG_DELAYS_LO: dly_lo_q  = value[4*DLY_W-1:0];
      CFG_DELAYS_HI: dly_hi_q  = value[2*DLY_W-1:0];
      CFG_GAINS_LO:  gain_lo_q = value[4*GAIN_W-1:0];
      CFG_GAINS_HI:  gain_hi_q = value[2*GAIN_W-1:0];
      CFG_ALPHA:     alpha_q   = value[ALPHA_W-1:0];
      CFG_MIX:       mix_q     = value[MIX_W-1:0];
      default: ;
    endcase
    settings_written++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic offer_sample(input sample_t smp, input bit fixed,
                              input logic [OUT_W-1:0] typed);
    logic [OUT_W-1:0] model_out;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    model_out = predict_reflections(smp);
    reflections_due.push_back(fixed ? typed : model_out);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_settled();
    s_axis_tvalid <= 1'b0;
    while (reflections_due.size() != 0) @(negedge clk_i);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    logic [OUT_W-1:0] due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (reflections_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected beat, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        due = reflections_due.pop_front();
        for (int k = 0; k < OUT_TAPS; k++) begin
          if (m_axis_tdata[SAMPLE_W*k +: SAMPLE_W] !== due[SAMPLE_W*k +: SAMPLE_W]) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: reflection_tap%0d expected %0d actual %0d", $time, k,
                       $signed(due[SAMPLE_W*k +: SAMPLE_W]),
                       $signed(m_axis_tdata[SAMPLE_W*k +: SAMPLE_W]));
          end
        end
      end
    end
  end

  // Result side back-pressure, with one long hold.
  always @(negedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = RX_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sample_t           smp;
    logic [DLY_W-1:0]  dly [OUT_TAPS];
    logic [GAIN_W-1:0] gn [OUT_TAPS];
    logic [ALPHA_W-1:0] alpha_v;
    logic [MIX_W-1:0]  mix_v;
    logic [CFG_DW-1:0] dl, dh, gl, gh, al, mx;
    bit                after_sample;
    int                mode;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = '0;
    cfg_data_i    = '0;
    after_sample  = 1'b0;

    dly_lo_q    = DELAYS_LO_RST;
    dly_hi_q    = DELAYS_HI_RST;
    gain_lo_q   = '0;
    gain_hi_q   = '0;
    alpha_q     = '0;
    mix_q       = '0;
    echo_wr_ptr = '0;
    foreach (echo_ring[i]) echo_ring[i] = '0;
    foreach (damp_mem[i]) damp_mem[i] = 0;

    // Out of reset every gain is zero, so all taps stay silent.
    add_row(ROW_SAMPLE, '0, 64'h7FFF, 1, '0);
    add_row(ROW_SAMPLE, '0, 64'h8000, 1, '0);
    add_row(ROW_SAMPLE, '0, 64'h0001, 1, '0);
    // Zero delay, unity gain and mix, no damping: each tap repeats the input.
    add_row(ROW_SETTING, CFG_DELAYS_LO, '0, 0, '0);
    add_row(ROW_SETTING, CFG_DELAYS_HI, '0, 0, '0);
    add_row(ROW_SETTING, CFG_GAINS_LO, {4{16'h8000}}, 0, '0);
    add_row(ROW_SETTING, CFG_GAINS_HI, CFG_DW'({2{16'h8000}}), 0, '0);
    add_row(ROW_SETTING, CFG_MIX, 64'h8000, 0, '0);
    add_row(ROW_SAMPLE, '0, 64'h7FFF, 1, {6{16'h7FFF}});
    add_row(ROW_SAMPLE, '0, 64'h8000, 1, {6{16'h8000}});
    add_row(ROW_SAMPLE, '0, 64'h0000, 1, '0);
    add_row(ROW_SAMPLE, '0, 64'hFFFF, 1, {6{16'hFFFF}});
    add_row(ROW_SAMPLE, '0, 64'h0001, 1, {6{16'h0001}});
    // Gains and mix above unity clip at both rails.
    add_row(ROW_SETTING, CFG_GAINS_LO, {4{16'hFFFF}}, 0, '0);
    add_row(ROW_SETTING, CFG_GAINS_HI, CFG_DW'({2{16'hFFFF}}), 0, '0);
    add_row(ROW_SETTING, CFG_MIX, 64'hFFFF, 0, '0);
    add_row(ROW_SAMPLE, '0, 64'h7FFF, 1, {6{16'h7FFF}});
    add_row(ROW_SAMPLE, '0, 64'h8000, 1, {6{16'h8000}});
    add_row(ROW_SAMPLE, '0, 64'h0000, 1, '0);
    // Writes to unmapped indexes leave the gains alone.
    add_row(ROW_SETTING, CFG_SPARE_A, '0, 0, '0);
    add_row(ROW_SETTING, CFG_SPARE_B, '0, 0, '0);
    add_row(ROW_SAMPLE, '0, 64'h7FFF, 1, {6{16'h7FFF}});
    // Mixed delays up to the ring end, mixed gains, damping above the nominal maximum.
    add_row(ROW_SETTING, CFG_DELAYS_LO, CFG_DW'({14'd3, 14'd2, 14'd1, 14'd0}), 0, '0);
    add_row(ROW_SETTING, CFG_DELAYS_HI, CFG_DW'({14'd16383, 14'd100}), 0, '0);
    add_row(ROW_SETTING, CFG_GAINS_LO, {16'h8000, 16'h4000, 16'h1234, 16'hFFFF}, 0, '0);
    add_row(ROW_SETTING, CFG_GAINS_HI, CFG_DW'({16'h0001, 16'h7FFF}), 0, '0);
    add_row(ROW_SETTING, CFG_ALPHA, 64'h7FFF, 0, '0);
    add_row(ROW_SETTING, CFG_MIX, 64'h8000, 0, '0);
    add_row(ROW_SAMPLE, '0, 64'd20000, 0, '0);
    add_row(ROW_SAMPLE, '0, 64'hB1E0, 0, '0);
    add_row(ROW_SAMPLE, '0, 64'h7FFF, 0, '0);
    add_row(ROW_SAMPLE, '0, 64'h8000, 0, '0);
    add_row(ROW_SAMPLE, '0, 64'd5, 0, '0);
    add_row(ROW_SETTING, CFG_ALPHA, 64'd27853, 0, '0);
    add_row(ROW_SAMPLE, '0, 64'hFFFF, 0, '0);
    add_row(ROW_SAMPLE, '0, 64'd12345, 0, '0);
    add_row(ROW_SAMPLE, '0, 64'h0000, 0, '0);

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SETTING) begin
        if (after_sample) wait_settled();
        write_setting(dir_rows[i].addr, dir_rows[i].value);
        after_sample = 1'b0;
      end else begin
        offer_sample(sample_t'(dir_rows[i].value[SAMPLE_W-1:0]), dir_rows[i].fixed,
                     dir_rows[i].reflections);
        after_sample = 1'b1;
      end
    end
    wait_settled();

    for (int p = 0; p < RAND_PHASES; p++) begin
      mode = p % 4;
      for (int k = 0; k < OUT_TAPS; k++) begin
        if (p == 0) begin
          dly[k] = '1;
          gn[k]  = '1;
        end else if (p == 1) begin
          dly[k] = '0;
          gn[k]  = 16'h8000;
        end else begin
          case ($urandom_range(3))
            0: dly[k] = DLY_W'($urandom_range(15));
            1: dly[k] = DLY_W'($urandom_range(200));
            2: dly[k] = DLY_W'($urandom);
            default: dly[k] = '1;
          endcase
          case ($urandom_range(3))
            0: gn[k] = 16'h8000;
            1: gn[k] = GAIN_W'($urandom);
            2: gn[k] = GAIN_W'($urandom_range(32768));
            default: gn[k] = '1;
          endcase
        end
      end
      if (p == 0) begin
        alpha_v = '1;
        mix_v   = '1;
      end else if (p == 1) begin
        alpha_v = '0;
        mix_v   = 16'h8000;
      end else begin
        case ($urandom_range(3))
          0: alpha_v = '0;
          1: alpha_v = 15'd27853;
          2: alpha_v = ALPHA_W'($urandom);
          default: alpha_v = ALPHA_W'($urandom_range(27853));
        endcase
        case ($urandom_range(3))
          0: mix_v = 16'h8000;
          1: mix_v = MIX_W'($urandom);
          2: mix_v = MIX_W'($urandom_range(32768));
          default: mix_v = '1;
        endcase
      end
      // Bits above each register's width carry noise and must be dropped.
      dl = {$urandom, $urandom};
      dh = {$urandom, $urandom};
      gh = {$urandom, $urandom};
      al = {$urandom, $urandom};
      mx = {$urandom, $urandom};
      dl[4*DLY_W-1:0]  = {dly[3], dly[2], dly[1], dly[0]};
      dh[2*DLY_W-1:0]  = {dly[5], dly[4]};
      gl               = {gn[3], gn[2], gn[1], gn[0]};
      gh[2*GAIN_W-1:0] = {gn[5], gn[4]};
      al[ALPHA_W-1:0]  = alpha_v;
      mx[MIX_W-1:0]    = mix_v;
      write_setting(CFG_DELAYS_LO, dl);
      write_setting(CFG_DELAYS_HI, dh);
      write_setting(CFG_GAINS_LO, gl);
      write_setting(CFG_GAINS_HI, gh);
      write_setting(CFG_ALPHA, al);
      write_setting(CFG_MIX, mx);
      if ($urandom_range(1)) write_setting(CFG_SPARE_A, {$urandom, $urandom});
      if ($urandom_range(1)) write_setting(CFG_SPARE_B, {$urandom, $urandom});

      case (mode)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 65;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 65;
        end
        default: begin
          tx_idle_pct  = 25;
          rx_stall_pct = 25;
        end
      endcase
      if (p == 2) hold_token++;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(15))
          0: smp = 16'sh7FFF;
          1: smp = sample_t'(16'h8000);
          2: smp = '0;
          3: smp = '1;
          default: smp = sample_t'(SAMPLE_W'($urandom));
        endcase
        offer_sample(smp, 0, '0);
      end
      wait_settled();
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (reflections_due.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived", $time, reflections_due.size());
    end

    $display("Checked %0d result beats for %0d samples over %0d register writes.",
             results_seen, items_sent, settings_written);
    $display("Flow patterns ran free, with sender gaps, receiver stalls, both, and one long hold.");
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
